// ===== hw/rtl/cbz_pkg.sv =====
// Shared types, constants and a helper function of the cubic Bezier evaluator.
`default_nettype none
package cbz_pkg;

    // Field widths of the request, result and register words.
    localparam int COORD_W  = 24;
    localparam int T_W      = 17;
    localparam int DIST_W   = 26;
    localparam int SUBDIV_W = 11;
    localparam int LEN_W    = 25;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int MAX_SUBDIVISIONS_DEF = 1024;

    localparam logic [T_W-1:0]   T_ONE   = 17'd65536;
    localparam logic [LEN_W-1:0] LEN_MAX = 25'd33554431;

    // Request modes.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_POINT    = 2'd0;
    localparam mode_t MODE_LENGTH   = 2'd1;
    localparam mode_t MODE_DISTANCE = 2'd2;

    // Register indexes of the control points.
    typedef enum logic [2:0] {
        REG_START_X,
        REG_START_Y,
        REG_GUIDE1_X,
        REG_GUIDE1_Y,
        REG_GUIDE2_X,
        REG_GUIDE2_Y,
        REG_END_X,
        REG_END_Y
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHORD_T,
        ST_TDIV,
        ST_EVAL,
        ST_SQUARE,
        ST_SQRT,
        ST_STEP,
        ST_IMUL,
        ST_IDIV,
        ST_FINISH
    } state_t;

    // Saturate a wide signed value to the coordinate range.
    function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [27:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 28'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -28'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cbz_req_if.sv =====
// Request channel of the cubic Bezier evaluator.
`default_nettype none
interface cbz_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic [cbz_pkg::T_W-1:0]             param_t;
    logic signed [cbz_pkg::DIST_W-1:0]   distance;
    logic [cbz_pkg::SUBDIV_W-1:0]        subdivisions;

    modport source (output valid, mode, param_t, distance, subdivisions, input ready);
    modport sink (input valid, mode, param_t, distance, subdivisions, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cbz_res_if.sv =====
// Result channel of the cubic Bezier evaluator.
`default_nettype none
interface cbz_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [cbz_pkg::COORD_W-1:0]  point_x;
    logic signed [cbz_pkg::COORD_W-1:0]  point_y;
    logic [cbz_pkg::LEN_W-1:0]           arc_length;

    modport source (output valid, point_x, point_y, arc_length, input ready);
    modport sink (input valid, point_x, point_y, arc_length, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cubic_bezier_2d_evaluator_top.sv =====
// Cubic Bezier evaluator: point at t, chord arc length and point at distance.
// One request is worked on at a time, through a single shared multiplier, a
// bit-serial square root and a bit-serial divider under one sequencer; the
// block is not ready while a request is in progress, though it takes a new
// request while the previous result word still waits at the output. Each
// chord of modes 1 and 2 loads and runs the chord parameter division,
// evaluates the curve on the shared multiplier, forms the squares, takes
// the square root and accumulates; mode 2 adds the two interpolation
// divisions on the chord that holds the distance. A result word that is
// still waiting at the output holds the next result in its last step.
// The control points are written over the APB port; the user must write
// them only while the block is idle, the block itself does not enforce it.
`default_nettype none
module cubic_bezier_2d_evaluator_top #(
    parameter int MAX_SUBDIVISIONS = cbz_pkg::MAX_SUBDIVISIONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cbz_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [cbz_pkg::DATA_W-1:0]    pwdata,
    output logic      [cbz_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    cbz_req_if.sink                            req,
    cbz_res_if.source                          res
);

    localparam int CW = cbz_pkg::COORD_W;
    localparam int NW = cbz_pkg::SUBDIV_W;

    // Control point registers.
    logic signed [CW-1:0] start_x_reg, start_y_reg, guide1_x_reg, guide1_y_reg;
    logic signed [CW-1:0] guide2_x_reg, guide2_y_reg, end_x_reg, end_y_reg;
    logic                 cfg_wr;
    logic signed [CW-1:0] cfg_data;

    // Sequencer registers.
    cbz_pkg::state_t state_reg, state_next;
    logic [5:0]      cnt_reg, cnt_next;
    cbz_pkg::mode_t  mode_reg, mode_next;
    logic [cbz_pkg::T_W-1:0] t_reg, t_next;
    logic signed [cbz_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [NW-1:0]   n_reg, n_next, k_reg, k_next;
    logic            axis_reg, axis_next;

    // Datapath registers.
    logic signed [60:0] prod_reg, prod_next;
    logic [32:0]     uu_reg, uu_next, tt_reg, tt_next, ut_reg, ut_next;
    logic [32:0]     w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next, w3_reg, w3_next;
    logic signed [59:0] accx_reg, accx_next, accy_reg, accy_next;
    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next, nx_reg, nx_next, ny_reg, ny_next;
    logic signed [CW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [49:0]     sq_reg, sq_next, root_reg, root_next, bit_reg, bit_next;
    logic [24:0]     seg_reg, seg_next, num_reg, num_next;
    logic [35:0]     len_reg, len_next;
    logic [24:0]     rem_reg, rem_next, divisor_reg, divisor_next;
    logic [50:0]     quo_reg, quo_next;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    logic signed [CW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [cbz_pkg::LEN_W-1:0] out_len_reg, out_len_next;

    // Combinational helpers.
    logic signed [34:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [60:0] mul_p;
    logic [cbz_pkg::T_W-1:0] u_val, t_clamp;
    logic [NW-1:0]   n_clamp;
    logic signed [CW-1:0] coord_x, coord_y;
    logic [51:0]     p3;
    logic signed [59:0] rnd_x, rnd_y;
    logic signed [24:0] dx, dy, delta;
    logic [24:0]     mag;
    logic signed [CW-1:0] p_sel;
    logic signed [27:0] interp_sum;
    logic [26:0]     div_trial;
    logic [24:0]     div_rem;
    logic [50:0]     div_quo;
    logic [50:0]     sqrt_sum;
    logic [35:0]     acc_plus;
    logic            accept;

    // APB port: pready is held high, so there are no wait states; reads are sign extended.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_data = pwdata[CW-1:0];

    always_comb
    begin
        case (cbz_pkg::reg_idx_t'(paddr[4:2]))
            cbz_pkg::REG_START_X:  prdata = 32'(start_x_reg);
            cbz_pkg::REG_START_Y:  prdata = 32'(start_y_reg);
            cbz_pkg::REG_GUIDE1_X: prdata = 32'(guide1_x_reg);
            cbz_pkg::REG_GUIDE1_Y: prdata = 32'(guide1_y_reg);
            cbz_pkg::REG_GUIDE2_X: prdata = 32'(guide2_x_reg);
            cbz_pkg::REG_GUIDE2_Y: prdata = 32'(guide2_y_reg);
            cbz_pkg::REG_END_X:    prdata = 32'(end_x_reg);
            cbz_pkg::REG_END_Y:    prdata = 32'(end_y_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            guide1_x_reg <= '0;
            guide1_y_reg <= '0;
            guide2_x_reg <= '0;
            guide2_y_reg <= '0;
            end_x_reg    <= '0;
            end_y_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cbz_pkg::reg_idx_t'(paddr[4:2]))
                cbz_pkg::REG_START_X:  start_x_reg  <= cfg_data;
                cbz_pkg::REG_START_Y:  start_y_reg  <= cfg_data;
                cbz_pkg::REG_GUIDE1_X: guide1_x_reg <= cfg_data;
                cbz_pkg::REG_GUIDE1_Y: guide1_y_reg <= cfg_data;
                cbz_pkg::REG_GUIDE2_X: guide2_x_reg <= cfg_data;
                cbz_pkg::REG_GUIDE2_Y: guide2_y_reg <= cfg_data;
                cbz_pkg::REG_END_X:    end_x_reg    <= cfg_data;
                cbz_pkg::REG_END_Y:    end_y_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Handshake.
    assign req.ready      = (state_reg == cbz_pkg::ST_IDLE);
    assign accept         = req.valid && req.ready;
    assign res.valid      = out_valid_reg;
    assign res.point_x    = out_x_reg;
    assign res.point_y    = out_y_reg;
    assign res.arc_length = out_len_reg;

    // Request field saturation.
    assign t_clamp = (req.param_t > cbz_pkg::T_ONE) ? cbz_pkg::T_ONE : req.param_t;
    assign n_clamp = (32'(req.subdivisions) > 32'(MAX_SUBDIVISIONS)) ?
                     NW'(MAX_SUBDIVISIONS) : req.subdivisions;

    // Control point selection for the weighted sums.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd3:    begin coord_x = start_x_reg;  coord_y = start_y_reg;  end
            2'd0:    begin coord_x = guide1_x_reg; coord_y = guide1_y_reg; end
            2'd1:    begin coord_x = guide2_x_reg; coord_y = guide2_y_reg; end
            default: begin coord_x = end_x_reg;    coord_y = end_y_reg;    end
        endcase
    end

    // Fixed helper arithmetic.
    assign u_val    = cbz_pkg::T_ONE - t_reg;
    assign p3       = {prod_reg[50:0], 1'b0} + {1'b0, prod_reg[50:0]};
    assign rnd_x    = accx_reg + 60'sh0_0000_0008_0000_000;
    assign rnd_y    = accy_reg + 60'sh0_0000_0008_0000_000;
    assign dx       = 25'(nx_reg) - 25'(px_reg);
    assign dy       = 25'(ny_reg) - 25'(py_reg);
    assign p_sel    = axis_reg ? py_reg : px_reg;
    assign delta    = axis_reg ? (25'(ny_reg) - 25'(py_reg)) : (25'(nx_reg) - 25'(px_reg));
    assign mag      = delta[24] ? 25'(-delta) : 25'(delta);
    assign sqrt_sum = {1'b0, root_reg} + {1'b0, bit_reg};
    assign acc_plus = len_reg + 36'(seg_reg);

    // Divider step: one quotient bit a cycle.
    assign div_trial = {1'b0, rem_reg, quo_reg[50]} - {2'b0, divisor_reg};
    always_comb
    begin
        if (!div_trial[26])
        begin
            div_rem = div_trial[24:0];
            div_quo = {quo_reg[49:0], 1'b1};
        end
        else
        begin
            div_rem = {rem_reg[23:0], quo_reg[50]};
            div_quo = {quo_reg[49:0], 1'b0};
        end
    end

    // Interpolated coordinate from the finished quotient.
    assign interp_sum = delta[24] ? (28'(p_sel) - 28'(div_quo[25:0]))
                                  : (28'(p_sel) + 28'(div_quo[25:0]));

    // Shared multiplier.
    assign mul_p = 61'(mul_a) * 61'(mul_b);

    // Sequencer: next state, multiplier operands and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        t_next         = t_reg;
        dist_next      = dist_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        axis_next      = axis_reg;
        prod_next      = mul_p;
        uu_next        = uu_reg;
        tt_next        = tt_reg;
        ut_next        = ut_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        sq_next        = sq_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        seg_next       = seg_reg;
        num_next       = num_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        divisor_next   = divisor_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_len_next   = out_len_reg;
        out_valid_next = out_valid_reg && !res.ready;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            // Take a request and pick its first phase.
            cbz_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    t_next    = t_clamp;
                    dist_next = req.distance;
                    n_next    = n_clamp;
                    k_next    = NW'(1);
                    px_next   = start_x_reg;
                    py_next   = start_y_reg;
                    len_next  = '0;
                    rx_next   = '0;
                    ry_next   = '0;
                    cnt_next  = '0;
                    case (req.mode)
                        cbz_pkg::MODE_POINT:
                        begin
                            state_next = cbz_pkg::ST_EVAL;
                        end
                        cbz_pkg::MODE_LENGTH:
                        begin
                            state_next = (n_clamp == '0) ? cbz_pkg::ST_FINISH
                                                         : cbz_pkg::ST_CHORD_T;
                        end
                        cbz_pkg::MODE_DISTANCE:
                        begin
                            if (n_clamp == '0 || req.distance <= 0)
                            begin
                                rx_next    = start_x_reg;
                                ry_next    = start_y_reg;
                                state_next = cbz_pkg::ST_FINISH;
                            end
                            else
                            begin
                                state_next = cbz_pkg::ST_CHORD_T;
                            end
                        end
                        default:
                        begin
                            state_next = cbz_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            // Load the divider with k*65536 + n/2 over n.
            cbz_pkg::ST_CHORD_T:
            begin
                quo_next     = {27'({k_reg, 16'b0}) + 27'(n_reg >> 1), 24'b0};
                rem_next     = '0;
                divisor_next = 25'(n_reg);
                cnt_next     = '0;
                state_next   = cbz_pkg::ST_TDIV;
            end

            cbz_pkg::ST_TDIV:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd26)
                begin
                    t_next     = div_quo[cbz_pkg::T_W-1:0];
                    cnt_next   = '0;
                    state_next = cbz_pkg::ST_EVAL;
                end
            end

            // Bernstein weights, then the two weighted sums; each product is
            // used in the cycle after it is formed.
            cbz_pkg::ST_EVAL:
            begin
                cnt_next = cnt_reg + 6'd1;
                case (cnt_reg)
                    6'd0:    begin mul_a = 35'(u_val); mul_b = 26'(u_val); end
                    6'd1:    begin mul_a = 35'(t_reg); mul_b = 26'(t_reg); end
                    6'd2:    begin mul_a = 35'(u_val); mul_b = 26'(t_reg); end
                    6'd3:    begin mul_a = 35'(uu_reg); mul_b = 26'(u_val); end
                    6'd4:    begin mul_a = 35'(uu_reg); mul_b = 26'(t_reg); end
                    6'd5:    begin mul_a = 35'(ut_reg); mul_b = 26'(t_reg); end
                    6'd6:    begin mul_a = 35'(tt_reg); mul_b = 26'(t_reg); end
                    6'd7, 6'd11: begin mul_a = 35'(w0_reg); mul_b = 26'(coord_x); end
                    6'd8, 6'd12: begin mul_a = 35'(w1_reg); mul_b = 26'(coord_x); end
                    6'd9, 6'd13: begin mul_a = 35'(w2_reg); mul_b = 26'(coord_x); end
                    6'd10, 6'd14: begin mul_a = 35'(w3_reg); mul_b = 26'(coord_x); end
                    default: ;
                endcase
                if (cnt_reg >= 6'd11 && cnt_reg <= 6'd14)
                begin
                    mul_b = 26'(coord_y);
                end
                case (cnt_reg)
                    6'd1: uu_next = prod_reg[32:0];
                    6'd2: tt_next = prod_reg[32:0];
                    6'd3: ut_next = prod_reg[32:0];
                    6'd4: w0_next = 33'(({2'b0, prod_reg[48:0]} + 51'd32768) >> 16);
                    6'd5: w1_next = 33'((p3 + 52'd32768) >> 16);
                    6'd6: w2_next = 33'((p3 + 52'd32768) >> 16);
                    6'd7: w3_next = 33'(({2'b0, prod_reg[48:0]} + 51'd32768) >> 16);
                    6'd8: accx_next = prod_reg[59:0];
                    6'd9, 6'd10, 6'd11: accx_next = accx_reg + prod_reg[59:0];
                    6'd12: accy_next = prod_reg[59:0];
                    6'd13, 6'd14, 6'd15: accy_next = accy_reg + prod_reg[59:0];
                    6'd16:
                    begin
                        nx_next  = cbz_pkg::clamp_coord(rnd_x[59:32]);
                        ny_next  = cbz_pkg::clamp_coord(rnd_y[59:32]);
                        cnt_next = '0;
                        if (mode_reg == cbz_pkg::MODE_POINT)
                        begin
                            rx_next    = cbz_pkg::clamp_coord(rnd_x[59:32]);
                            ry_next    = cbz_pkg::clamp_coord(rnd_y[59:32]);
                            state_next = cbz_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = cbz_pkg::ST_SQUARE;
                        end
                    end
                    default: ;
                endcase
            end

            // Squared chord length.
            cbz_pkg::ST_SQUARE:
            begin
                cnt_next = cnt_reg + 6'd1;
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = 35'(dx);
                        mul_b = 26'(dx);
                    end
                    6'd1:
                    begin
                        mul_a   = 35'(dy);
                        mul_b   = 26'(dy);
                        sq_next = prod_reg[49:0];
                    end
                    default:
                    begin
                        sq_next    = sq_reg + prod_reg[49:0];
                        root_next  = '0;
                        bit_next   = 50'(1) << 48;
                        state_next = cbz_pkg::ST_SQRT;
                    end
                endcase
            end

            // Integer square root, one result bit a cycle.
            cbz_pkg::ST_SQRT:
            begin
                if ({1'b0, sq_reg} >= sqrt_sum)
                begin
                    sq_next   = 50'({1'b0, sq_reg} - sqrt_sum);
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    seg_next   = root_next[24:0];
                    state_next = cbz_pkg::ST_STEP;
                end
            end

            // Accumulate the chord or find the chord that holds the distance.
            cbz_pkg::ST_STEP:
            begin
                if (mode_reg == cbz_pkg::MODE_DISTANCE && seg_reg != '0 &&
                    acc_plus >= 36'(dist_reg))
                begin
                    num_next   = 25'(36'(dist_reg) - len_reg);
                    axis_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = cbz_pkg::ST_IMUL;
                end
                else
                begin
                    len_next = acc_plus;
                    px_next  = nx_reg;
                    py_next  = ny_reg;
                    if (k_reg == n_reg)
                    begin
                        rx_next    = (mode_reg == cbz_pkg::MODE_DISTANCE) ? end_x_reg : '0;
                        ry_next    = (mode_reg == cbz_pkg::MODE_DISTANCE) ? end_y_reg : '0;
                        state_next = cbz_pkg::ST_FINISH;
                    end
                    else
                    begin
                        k_next     = k_reg + NW'(1);
                        state_next = cbz_pkg::ST_CHORD_T;
                    end
                end
            end

            // Offset numerator |delta|*(d - acc), then load the divider.
            cbz_pkg::ST_IMUL:
            begin
                if (cnt_reg == '0)
                begin
                    mul_a    = 35'(mag);
                    mul_b    = 26'(num_reg);
                    cnt_next = 6'd1;
                end
                else
                begin
                    quo_next     = 51'(prod_reg[49:0]) + 51'(seg_reg >> 1);
                    rem_next     = '0;
                    divisor_next = seg_reg;
                    cnt_next     = '0;
                    state_next   = cbz_pkg::ST_IDIV;
                end
            end

            cbz_pkg::ST_IDIV:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd50)
                begin
                    cnt_next = '0;
                    if (!axis_reg)
                    begin
                        rx_next    = cbz_pkg::clamp_coord(interp_sum);
                        axis_next  = 1'b1;
                        state_next = cbz_pkg::ST_IMUL;
                    end
                    else
                    begin
                        ry_next    = cbz_pkg::clamp_coord(interp_sum);
                        state_next = cbz_pkg::ST_FINISH;
                    end
                end
            end

            // Hand the result word to the output register once it is free.
            cbz_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = rx_reg;
                    out_y_next     = ry_reg;
                    if (mode_reg == cbz_pkg::MODE_LENGTH)
                    begin
                        out_len_next = (len_reg > 36'(cbz_pkg::LEN_MAX)) ?
                                       cbz_pkg::LEN_MAX : len_reg[cbz_pkg::LEN_W-1:0];
                    end
                    else
                    begin
                        out_len_next = '0;
                    end
                    state_next = cbz_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cbz_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbz_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        t_reg       <= t_next;
        dist_reg    <= dist_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        axis_reg    <= axis_next;
        prod_reg    <= prod_next;
        uu_reg      <= uu_next;
        tt_reg      <= tt_next;
        ut_reg      <= ut_next;
        w0_reg      <= w0_next;
        w1_reg      <= w1_next;
        w2_reg      <= w2_next;
        w3_reg      <= w3_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        sq_reg      <= sq_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        seg_reg     <= seg_next;
        num_reg     <= num_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_len_reg <= out_len_next;
    end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the cubic Bezier evaluator: directed and random requests.
`timescale 1ns / 1ps
module testbench;

    localparam cbz_pkg::mode_t MODE_UNDEFINED = 2'd3;
    localparam int    CYCLE_LIMIT    = 6000000;
    localparam int    MAX_CHORDS     = 1024;

    typedef struct {
        cbz_pkg::mode_t                     mode;
        logic [cbz_pkg::T_W-1:0]            t;
        logic signed [cbz_pkg::DIST_W-1:0]  target;
        logic [cbz_pkg::SUBDIV_W-1:0]       n;
    } request_t;

    typedef struct {
        logic signed [cbz_pkg::COORD_W-1:0] x;
        logic signed [cbz_pkg::COORD_W-1:0] y;
        logic [cbz_pkg::LEN_W-1:0]          len;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [cbz_pkg::ADDR_W-1:0] paddr = '0;
    logic [cbz_pkg::DATA_W-1:0] pwdata = '0;
    logic [cbz_pkg::DATA_W-1:0] prdata;
    logic pready;

    cbz_req_if req_if();
    cbz_res_if res_if();

    cubic_bezier_2d_evaluator_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req_if), .res(res_if)
    );

    // Testbench copy of the control points, indexed as the registers are.
    longint   ctrl [8];
    request_t pending_requests [$];
    answer_t  expected_answers [$];
    request_t driven_request;
    int       fails = 0;
    int       accepted = 0;
    int       answers_seen = 0;
    int       mode_count [4];
    int       send_gap = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       hold_request = 1'b0;
    bit       calm = 1'b0;
    longint   cycles = 0;

    always #1 clk = ~clk;

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607)
        begin
            return 64'sd8388607;
        end
        if (v < -64'sd8388608)
        begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned bitpos = 64'd1 << 62;
        while (bitpos > v)
        begin
            bitpos = bitpos >> 2;
        end
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
            begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Curve point at t with Bernstein weights rounded to Q.32.
    function automatic void curve_point(longint unsigned t, output longint px, output longint py);
        longint unsigned u = 65536 - t;
        longint unsigned b [4];
        longint w [4];
        longint sx;
        longint sy;
        b[0] = u * u * u;
        b[1] = 3 * u * u * t;
        b[2] = 3 * u * t * t;
        b[3] = t * t * t;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = longint'((b[i] + 32768) >> 16);
        end
        sx = w[0] * ctrl[cbz_pkg::REG_START_X] + w[1] * ctrl[cbz_pkg::REG_GUIDE1_X]
           + w[2] * ctrl[cbz_pkg::REG_GUIDE2_X] + w[3] * ctrl[cbz_pkg::REG_END_X];
        sy = w[0] * ctrl[cbz_pkg::REG_START_Y] + w[1] * ctrl[cbz_pkg::REG_GUIDE1_Y]
           + w[2] * ctrl[cbz_pkg::REG_GUIDE2_Y] + w[3] * ctrl[cbz_pkg::REG_END_Y];
        px = clamp24((sx + (64'sd1 <<< 31)) >>> 32);
        py = clamp24((sy + (64'sd1 <<< 31)) >>> 32);
    endfunction

    function automatic longint unsigned chord_param(longint unsigned k, longint unsigned n);
        return (k * 65536 + n / 2) / n;
    endfunction

    function automatic longint unsigned chord_length(longint ax, longint ay, longint bx, longint by);
        longint dx = bx - ax;
        longint dy = by - ay;
        return int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    // Rounded linear step from p towards q by num/seg of the way.
    function automatic longint lerp_coord(longint p, longint q, longint unsigned num,
                                          longint unsigned seg);
        longint delta = q - p;
        longint unsigned mag = (delta < 0) ? -delta : delta;
        longint unsigned off = (mag * num + seg / 2) / seg;
        return clamp24((delta < 0) ? p - longint'(off) : p + longint'(off));
    endfunction

    // Expected result word for one request under the current control points.
    function automatic answer_t bezier_answer(request_t rq);
        answer_t a;
        longint unsigned t = rq.t;
        longint unsigned n = rq.n;
        longint target = rq.target;
        longint rx = 0;
        longint ry = 0;
        longint unsigned len = 0;
        longint px;
        longint py;
        longint nx;
        longint ny;
        longint unsigned seg;
        longint unsigned acc = 0;
        bit found = 1'b0;
        if (t > 65536)
        begin
            t = 65536;
        end
        if (n > MAX_CHORDS)
        begin
            n = MAX_CHORDS;
        end
        px = ctrl[cbz_pkg::REG_START_X];
        py = ctrl[cbz_pkg::REG_START_Y];
        if (rq.mode == cbz_pkg::MODE_POINT)
        begin
            curve_point(t, rx, ry);
        end
        else if (rq.mode == cbz_pkg::MODE_LENGTH)
        begin
            for (longint unsigned k = 1; k <= n; k++)
            begin
                curve_point(chord_param(k, n), nx, ny);
                len += chord_length(px, py, nx, ny);
                px = nx;
                py = ny;
            end
            if (len > cbz_pkg::LEN_MAX)
            begin
                len = cbz_pkg::LEN_MAX;
            end
        end
        else if (rq.mode == cbz_pkg::MODE_DISTANCE)
        begin
            if (n == 0 || target <= 0)
            begin
                rx = px;
                ry = py;
            end
            else
            begin
                for (longint unsigned k = 1; k <= n && !found; k++)
                begin
                    curve_point(chord_param(k, n), nx, ny);
                    seg = chord_length(px, py, nx, ny);
                    if (seg > 0 && acc + seg >= longint'(target))
                    begin
                        rx = lerp_coord(px, nx, target - acc, seg);
                        ry = lerp_coord(py, ny, target - acc, seg);
                        found = 1'b1;
                    end
                    else
                    begin
                        acc += seg;
                        px = nx;
                        py = ny;
                    end
                end
                if (!found)
                begin
                    rx = ctrl[cbz_pkg::REG_END_X];
                    ry = ctrl[cbz_pkg::REG_END_Y];
                end
            end
        end
        a.x = rx[cbz_pkg::COORD_W-1:0];
        a.y = ry[cbz_pkg::COORD_W-1:0];
        a.len = len[cbz_pkg::LEN_W-1:0];
        return a;
    endfunction

    // Request driver: takes words from the pending queue, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.mode <= cbz_pkg::MODE_POINT;
            req_if.param_t <= '0;
            req_if.distance <= '0;
            req_if.subdivisions <= '0;
        end
        else if (!(req_if.valid && !req_if.ready))
        begin
            if (req_if.valid)
            begin
                expected_answers.push_back(bezier_answer(driven_request));
                accepted++;
                mode_count[driven_request.mode]++;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                req_if.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0 && !calm && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 18);
                req_if.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                driven_request = pending_requests.pop_front();
                req_if.mode <= driven_request.mode;
                req_if.param_t <= driven_request.t;
                req_if.distance <= driven_request.target;
                req_if.subdivisions <= driven_request.n;
                req_if.valid <= 1'b1;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each word with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result word x=%0d y=%0d len=%0d",
                           res_if.point_x, res_if.point_y, res_if.arc_length);
                    fails++;
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (res_if.point_x !== e.x)
                    begin
                        $error("point_x: expected %0d, got %0d", e.x, res_if.point_x);
                        fails++;
                    end
                    if (res_if.point_y !== e.y)
                    begin
                        $error("point_y: expected %0d, got %0d", e.y, res_if.point_y);
                        fails++;
                    end
                    if (res_if.arc_length !== e.len)
                    begin
                        $error("arc_length: expected %0d, got %0d", e.len, res_if.arc_length);
                        fails++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 3000;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_point(cbz_pkg::reg_idx_t idx, longint value);
        logic [cbz_pkg::COORD_W-1:0] v = value[cbz_pkg::COORD_W-1:0];
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= cbz_pkg::ADDR_W'(int'(idx) * 4);
        pwdata <= {8'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ctrl[idx] = longint'(signed'(v));
    endtask

    task automatic load_curve(longint sx, longint sy, longint ax, longint ay,
                              longint bx, longint by, longint ex, longint ey);
        write_point(cbz_pkg::REG_START_X, sx);
        write_point(cbz_pkg::REG_START_Y, sy);
        write_point(cbz_pkg::REG_GUIDE1_X, ax);
        write_point(cbz_pkg::REG_GUIDE1_Y, ay);
        write_point(cbz_pkg::REG_GUIDE2_X, bx);
        write_point(cbz_pkg::REG_GUIDE2_Y, by);
        write_point(cbz_pkg::REG_END_X, ex);
        write_point(cbz_pkg::REG_END_Y, ey);
    endtask

    task automatic queue_request(cbz_pkg::mode_t m, int t, int d, int n);
        request_t rq;
        rq.mode = m;
        rq.t = cbz_pkg::T_W'(t);
        rq.target = cbz_pkg::DIST_W'(d);
        rq.n = cbz_pkg::SUBDIV_W'(n);
        pending_requests.push_back(rq);
    endtask

    // Waits until every queued word has been sent and answered.
    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (pending_requests.size() != 0 || req_if.valid || expected_answers.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic longint random_coord(int style);
        if (style == 0)
        begin
            return longint'(signed'(cbz_pkg::COORD_W'($urandom)));
        end
        if (style == 1)
        begin
            return longint'($urandom_range(0, 8192)) - 4096;
        end
        return $urandom_range(0, 1) ? 64'sd8388607 : -64'sd8388608;
    endfunction

    // One random request; unused fields carry random bits.
    function automatic request_t random_request();
        request_t rq;
        request_t probe;
        int pick = $urandom_range(0, 99);
        longint unsigned total;
        rq.mode = (pick < 30) ? cbz_pkg::MODE_POINT : (pick < 55) ? cbz_pkg::MODE_LENGTH :
                  (pick < 95) ? cbz_pkg::MODE_DISTANCE : MODE_UNDEFINED;
        rq.t = cbz_pkg::T_W'($urandom);
        rq.target = cbz_pkg::DIST_W'($urandom);
        rq.n = cbz_pkg::SUBDIV_W'($urandom);
        if (rq.mode == cbz_pkg::MODE_POINT && $urandom_range(0, 3) != 0)
        begin
            rq.t = cbz_pkg::T_W'($urandom_range(0, 65536));
        end
        if (rq.mode == cbz_pkg::MODE_LENGTH || rq.mode == cbz_pkg::MODE_DISTANCE)
        begin
            if ($urandom_range(0, 99) != 0)
            begin
                rq.n = cbz_pkg::SUBDIV_W'($urandom_range(0, 12));
            end
        end
        if (rq.mode == cbz_pkg::MODE_DISTANCE && $urandom_range(0, 4) != 0)
        begin
            probe = rq;
            probe.mode = cbz_pkg::MODE_LENGTH;
            total = bezier_answer(probe).len;
            rq.target = cbz_pkg::DIST_W'($urandom_range(0, 32'(total + total / 8 + 1)));
        end
        return rq;
    endfunction

    initial
    begin
        int style;
        for (int i = 0; i < 8; i++)
        begin
            ctrl[i] = 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            mode_count[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a gentle curve.
        load_curve(0, 0, 2560, 10240, 12800, -5120, 15360, 0);
        queue_request(cbz_pkg::MODE_POINT, 0, 0, 0);
        queue_request(cbz_pkg::MODE_POINT, 65536, 0, 0);
        queue_request(cbz_pkg::MODE_POINT, 131071, -1, 2047);
        queue_request(cbz_pkg::MODE_POINT, 32768, 33554431, 1);
        queue_request(cbz_pkg::MODE_LENGTH, 0, 0, 0);
        queue_request(cbz_pkg::MODE_LENGTH, 0, 0, 1);
        queue_request(cbz_pkg::MODE_LENGTH, 131071, -33554432, 1024);
        queue_request(cbz_pkg::MODE_LENGTH, 0, 0, 2047);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 0, 8);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, -33554432, 8);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 5000, 0);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 5000, 8);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 33554431, 8);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 9000, 1024);
        queue_request(MODE_UNDEFINED, 65536, 5000, 8);
        drain();

        // Degenerate curve: every chord has length zero.
        load_curve(777, -777, 777, -777, 777, -777, 777, -777);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 1, 4);
        queue_request(cbz_pkg::MODE_LENGTH, 0, 0, 4);
        drain();

        // Corner to corner with extreme guides, at the limits of the coordinate range.
        load_curve(-8388608, -8388608, 8388607, -8388608,
                   -8388608, 8388607, 8388607, 8388607);
        queue_request(cbz_pkg::MODE_LENGTH, 0, 0, 64);
        queue_request(cbz_pkg::MODE_POINT, 21845, 0, 0);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 33554431, 16);
        queue_request(cbz_pkg::MODE_DISTANCE, 0, 20000000, 16);
        drain();

        // Random phases under several control point settings.
        for (int phase = 0; phase < 6; phase++)
        begin
            style = phase % 3;
            load_curve(random_coord(style), random_coord(style), random_coord(style),
                       random_coord(style), random_coord(style), random_coord(style),
                       random_coord(style), random_coord(style));
            if (phase == 1)
            begin
                hold_request = 1'b1;
            end
            if (phase == 5)
            begin
                calm = 1'b1;
            end
            for (int i = 0; i < 93; i++)
            begin
                pending_requests.push_back(random_request());
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Sent %0d requests (point %0d, length %0d, distance %0d, undefined %0d).",
                 accepted, mode_count[cbz_pkg::MODE_POINT], mode_count[cbz_pkg::MODE_LENGTH],
                 mode_count[cbz_pkg::MODE_DISTANCE], mode_count[MODE_UNDEFINED]);
        $display("Checked %0d result words over nine control point settings.", answers_seen);
        if (fails == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
